// File: src/fcet_pkg.sv
// ----------------------------------------------------------------------------
// fcet_pkg
// Shared types and constants for the framebuffer clear elision table.
// ----------------------------------------------------------------------------
package fcet_pkg;

    // Number of framebuffer ids held in the table (1 to 256).
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ID_W   = 32;
    localparam int BUF_W  = 3;
    localparam int STAT_W = 2;

    // Table word layout: id in the upper bits, clean flags in the lower bits.
    localparam int WORD_W = ID_W + BUF_W;

    localparam logic [BUF_W-1:0] ALL_CLEAN = '1;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 8;

    typedef enum logic [2:0] {
        CMD_BIND   = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_DRAW   = 3'd4,
        CMD_RESET  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EXISTED   = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// File: src/framebuffer_clear_elision_table_top.sv
// Lookup commands (create, delete, clear, draw) scan the table for the id; the
// id scan reads one table entry per cycle through the single memory read port.
// Bind, reset, scissored clears and unused codes skip the scan. One request is
// in work at a time.
// Reset: synchronous, active low; all entries invalid, current id zero.
// ----------------------------------------------------------------------------
// framebuffer_clear_elision_table_top
// Table of framebuffer ids with per-buffer clean flags. A clear returns only
// dirty buffers, or all when forced, scissored or not found; a draw dirties them.
// ----------------------------------------------------------------------------
module framebuffer_clear_elision_table_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: fb_id [31:0], buffer_bits [34:32], zero pad [39:35].
    input  logic [fcet_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: cmd [2:0], force_clear [3], scissor_on [4].
    input  logic [fcet_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tlast,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: clear_bits [2:0], status [4:3], zero pad [7:5].
    output logic [fcet_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import fcet_pkg::*;

    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx LAST_IDX = t_idx'(TABLE_ENTRIES - 1);

    // Table memory and its registered read data.
    logic [WORD_W-1:0] mem_tbl [TABLE_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;
    logic              mem_we;
    t_idx              mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Control and request state.
    t_state                   r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [ID_W-1:0]          r_cur_id, n_cur_id;
    logic [2:0]               r_cmd, n_cmd;
    logic [ID_W-1:0]          r_key, n_key;
    logic [BUF_W-1:0]         r_bits, n_bits;
    logic                     r_force, n_force;
    logic                     r_scissor, n_scissor;
    t_idx                     r_idx, n_idx;
    logic                     r_pend, n_pend;
    t_idx                     r_pend_idx, n_pend_idx;
    logic                     r_hit, n_hit;
    t_idx                     r_slot, n_slot;
    logic [BUF_W-1:0]         r_clean, n_clean;
    logic                     r_free_found, n_free_found;
    t_idx                     r_free_slot, n_free_slot;
    logic                     r_out_valid, n_out_valid;
    logic [BUF_W-1:0]         r_out_clear, n_out_clear;
    t_status                  r_out_status, n_out_status;

    logic                     s_accept;
    logic                     out_free;
    logic [ID_W-1:0]          rd_id;
    logic [BUF_W-1:0]         rd_clean;
    logic [BUF_W-1:0]         clr_bits;
    logic                     needs_scan;
    t_cmd                     in_cmd;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_status, r_out_clear};

    assign rd_id    = r_rd_data[WORD_W-1:BUF_W];
    assign rd_clean = r_rd_data[BUF_W-1:0];
    assign in_cmd   = t_cmd'(s_axis_tuser[2:0]);

    // Table memory: one write port, one registered read port on the scan index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tbl[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem_tbl[r_idx];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cur_id    <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cur_id    <= n_cur_id;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_bits       <= n_bits;
        r_force      <= n_force;
        r_scissor    <= n_scissor;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_clean      <= n_clean;
        r_free_found <= n_free_found;
        r_free_slot  <= n_free_slot;
        r_out_clear  <= n_out_clear;
        r_out_status <= n_out_status;
    end

    // Next state, table scan and read-modify-write of the matched entry.
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cur_id     = r_cur_id;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_bits       = r_bits;
        n_force      = r_force;
        n_scissor    = r_scissor;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_clean      = r_clean;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_clear  = r_out_clear;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_slot;
        mem_wdata    = {r_key, ALL_CLEAN};
        clr_bits     = r_bits;
        needs_scan   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_cmd        = s_axis_tuser[2:0];
                    n_bits       = s_axis_tdata[ID_W+BUF_W-1:ID_W];
                    n_force      = s_axis_tuser[3];
                    n_scissor    = s_axis_tuser[4];
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    // Clear and draw look up the bound id; reset inserts id zero.
                    case (in_cmd)
                        CMD_CLEAR, CMD_DRAW: n_key = r_cur_id;
                        CMD_RESET:           n_key = '0;
                        default:             n_key = s_axis_tdata[ID_W-1:0];
                    endcase
                    case (in_cmd)
                        CMD_CREATE, CMD_DELETE, CMD_DRAW: needs_scan = 1'b1;
                        CMD_CLEAR:                        needs_scan = !s_axis_tuser[4];
                        default:                          needs_scan = 1'b0;
                    endcase
                    n_state = needs_scan ? ST_SCAN : ST_FIN;
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle; compare the entry read last cycle.
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + t_idx'(1);
                end
                if (r_pend) begin
                    if (r_valid[r_pend_idx] && (rd_id == r_key)) begin
                        n_hit   = 1'b1;
                        n_slot  = r_pend_idx;
                        n_clean = rd_clean;
                        n_state = ST_FIN;
                    end else begin
                        // Remember the lowest free slot for a create.
                        if (!r_valid[r_pend_idx] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_slot  = r_pend_idx;
                        end
                        if (r_pend_idx == LAST_IDX) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    n_state      = ST_IDLE;
                    n_pend       = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_clear  = '0;
                    n_out_status = STAT_OK;
                    case (r_cmd)
                        CMD_BIND: begin
                            n_cur_id = r_key;
                        end
                        CMD_CREATE: begin
                            if (r_hit) begin
                                mem_we       = 1'b1;
                                n_out_status = STAT_EXISTED;
                            end else if (r_free_found) begin
                                mem_we               = 1'b1;
                                mem_waddr            = r_free_slot;
                                n_valid[r_free_slot] = 1'b1;
                            end else begin
                                n_out_status = STAT_FULL;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_hit) begin
                                n_valid[r_slot] = 1'b0;
                            end else begin
                                n_out_status = STAT_NOT_FOUND;
                            end
                        end
                        CMD_CLEAR: begin
                            if (r_scissor) begin
                                n_out_clear = r_bits;
                            end else if (!r_hit) begin
                                n_out_clear  = r_bits;
                                n_out_status = STAT_NOT_FOUND;
                            end else begin
                                // Drop buffers already clean unless forced.
                                clr_bits    = r_force ? r_bits : (r_bits & ~r_clean);
                                n_out_clear = clr_bits;
                                mem_we      = 1'b1;
                                mem_wdata   = {r_key, r_clean | clr_bits};
                            end
                        end
                        CMD_DRAW: begin
                            if (r_hit) begin
                                mem_we    = 1'b1;
                                mem_wdata = {r_key, r_clean & ~r_bits};
                            end else begin
                                n_out_status = STAT_NOT_FOUND;
                            end
                        end
                        CMD_RESET: begin
                            // Empty the table and place id zero in the first slot.
                            n_valid    = '0;
                            n_valid[0] = 1'b1;
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = {{ID_W{1'b0}}, ALL_CLEAN};
                        end
                        default: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The batch marker carries no meaning for the table; every request is one id.
    logic unused_tlast;
    assign unused_tlast = s_axis_tlast;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framebuffer clear elision table. A table of
// directed requests covers the extremes and the special cases. Random frames
// follow: a bind, then draws and clears on the bound id, mixed with creates,
// deletes, table resets and unused codes. Both stream sides stall at random.
// A local table model predicts every untyped result; all are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import fcet_pkg::*;

    localparam int          RANDOM_ITEMS = 910;
    localparam int          POOL_SIZE    = 24;
    localparam int          STALL_LIMIT  = 2000;
    localparam logic [2:0]  CMD_UNUSED6  = 3'd6;
    localparam logic [2:0]  CMD_UNUSED7  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] fb_id;
        logic [2:0]  bits;
        logic        force_clr;
        logic        scissor;
        logic        last;
    } t_fb_req;

    typedef struct packed {
        logic [2:0] clear_bits;
        t_status    status;
    } t_reply;

    // One directed row; rep repeats the request with fb_id counting up.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] fb_id;
        logic [2:0]  bits;
        logic        force_clr;
        logic        scissor;
        logic        last;
        logic [4:0]  rep;
        logic        typed;
        logic [2:0]  exp_bits;
        t_status     exp_stat;
    } t_dir_row;

    // Directed requests. Rows with typed set carry the result by hand.
    t_dir_row dir_rows [24] = '{
        // Empty table right after reset: every lookup misses.
        '{CMD_CLEAR,   32'h0000_0000, 3'd7, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd7, STAT_NOT_FOUND},
        '{CMD_DRAW,    32'h0000_0000, 3'd7, 1'b0, 1'b0, 1'b0, 5'd1,  1'b1, 3'd0, STAT_NOT_FOUND},
        '{CMD_DELETE,  32'h0000_0000, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_NOT_FOUND},
        // Table reset with every other field at its maximum.
        '{CMD_RESET,   32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_CLEAR,   32'h0000_0000, 3'd7, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_DRAW,    32'h0000_0000, 3'd5, 1'b0, 1'b0, 1'b0, 5'd1,  1'b0, 3'd0, STAT_OK},
        '{CMD_CLEAR,   32'h0000_0000, 3'd7, 1'b0, 1'b0, 1'b1, 5'd1,  1'b0, 3'd0, STAT_OK},
        // Scissored and forced clears.
        '{CMD_CLEAR,   32'h0000_0000, 3'd6, 1'b0, 1'b1, 1'b1, 5'd1,  1'b1, 3'd6, STAT_OK},
        '{CMD_CLEAR,   32'h0000_0000, 3'd7, 1'b1, 1'b0, 1'b1, 5'd1,  1'b1, 3'd7, STAT_OK},
        // Create of an existing id, then of the largest id.
        '{CMD_CREATE,  32'h0000_0000, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_EXISTED},
        '{CMD_CREATE,  32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_BIND,    32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_DRAW,    32'h0000_0000, 3'd2, 1'b0, 1'b0, 1'b0, 5'd1,  1'b0, 3'd0, STAT_OK},
        '{CMD_CLEAR,   32'h0000_0000, 3'd3, 1'b0, 1'b0, 1'b1, 5'd1,  1'b0, 3'd0, STAT_OK},
        // Bound id that is not in the table.
        '{CMD_BIND,    32'h1234_5678, 3'd0, 1'b0, 1'b0, 1'b0, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_CLEAR,   32'h0000_0000, 3'd1, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd1, STAT_NOT_FOUND},
        '{CMD_DELETE,  32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        // Unused command codes are ignored.
        '{CMD_UNUSED6, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_UNUSED7, 32'h0000_0000, 3'd0, 1'b0, 1'b0, 1'b0, 5'd1,  1'b1, 3'd0, STAT_OK},
        // Fill the table, overflow it, free one slot and reuse it.
        '{CMD_CREATE,  32'h0000_0001, 3'd0, 1'b0, 1'b0, 1'b1, 5'd15, 1'b0, 3'd0, STAT_OK},
        '{CMD_CREATE,  32'hA5A5_A5A5, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_FULL},
        '{CMD_DELETE,  32'h0000_0007, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_CREATE,  32'hA5A5_A5A5, 3'd0, 1'b0, 1'b0, 1'b1, 5'd1,  1'b1, 3'd0, STAT_OK},
        '{CMD_BIND,    32'h0000_0000, 3'd0, 1'b0, 1'b0, 1'b0, 5'd1,  1'b1, 3'd0, STAT_OK}
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // Local copy of the id table.
    bit   [TABLE_ENTRIES-1:0] fb_valid = '0;
    logic [31:0]              fb_ident [TABLE_ENTRIES];
    logic [2:0]               fb_clean [TABLE_ENTRIES];
    logic [31:0]              bound_id = '0;

    t_reply      replies_due [$];
    logic [31:0] id_pool [POOL_SIZE];
    bit          steady_run   = 1'b0;
    int unsigned n_sent       = 0;
    int unsigned n_errors     = 0;
    int unsigned n_full       = 0;
    int unsigned n_elided     = 0;
    int unsigned n_missing    = 0;
    int unsigned idle_cycles  = 0;

    framebuffer_clear_elision_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    function automatic int unsigned draw_gap();
        return steady_run ? 0 : $urandom_range(0, 9);
    endfunction

    // Returns the slot that holds id, or -1 when the id is not in the table.
    function automatic int find_fb(input logic [31:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (fb_valid[i] && fb_ident[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic t_status insert_fb(input logic [31:0] id);
        int slot;
        slot = find_fb(id);
        if (slot >= 0) begin
            fb_clean[slot] = ALL_CLEAN;
            return STAT_EXISTED;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!fb_valid[i]) begin
                fb_valid[i] = 1'b1;
                fb_ident[i] = id;
                fb_clean[i] = ALL_CLEAN;
                return STAT_OK;
            end
        end
        n_full++;
        return STAT_FULL;
    endfunction

    // Applies one request to the local table and returns the result it causes.
    function automatic t_reply apply_fb_command(input t_fb_req r);
        t_reply rep;
        int     slot;
        rep.clear_bits = '0;
        rep.status     = STAT_OK;
        case (r.cmd)
            CMD_BIND: bound_id = r.fb_id;
            CMD_CREATE: rep.status = insert_fb(r.fb_id);
            CMD_DELETE: begin
                slot = find_fb(r.fb_id);
                if (slot >= 0) fb_valid[slot] = 1'b0;
                else rep.status = STAT_NOT_FOUND;
            end
            CMD_CLEAR: begin
                rep.clear_bits = r.bits;
                if (!r.scissor) begin
                    slot = find_fb(bound_id);
                    if (slot < 0) begin
                        rep.status = STAT_NOT_FOUND;
                    end else begin
                        if (!r.force_clr) rep.clear_bits = r.bits & ~fb_clean[slot];
                        if (rep.clear_bits != r.bits) n_elided++;
                        fb_clean[slot] = fb_clean[slot] | rep.clear_bits;
                    end
                end
            end
            CMD_DRAW: begin
                slot = find_fb(bound_id);
                if (slot < 0) rep.status = STAT_NOT_FOUND;
                else fb_clean[slot] = fb_clean[slot] & ~r.bits;
            end
            CMD_RESET: begin
                fb_valid = '0;
                void'(insert_fb('0));
            end
            default: ;
        endcase
        if (rep.status == STAT_NOT_FOUND) n_missing++;
        return rep;
    endfunction

    // Most ids come from a small pool so that lookups hit; a few are fresh.
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_fb_req make_req(input logic [2:0] cmd, input logic [31:0] id);
        t_fb_req r;
        r.cmd       = cmd;
        r.fb_id     = id;
        r.bits      = 3'($urandom_range(0, 7));
        r.force_clr = ($urandom_range(0, 4) == 0);
        r.scissor   = ($urandom_range(0, 5) == 0);
        r.last      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offers one request after a random gap and records its expected result.
    task automatic send_req(input t_fb_req r, input bit typed, input t_reply want);
        int unsigned gap;
        t_reply      pred;
        gap = draw_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r.bits, r.fb_id};
        s_axis_tuser  <= {r.scissor, r.force_clr, r.cmd};
        s_axis_tlast  <= r.last;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = apply_fb_command(r);
        replies_due.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Holds requests back until every outstanding result has come.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Request side: reset, directed table, random frames, then the final wait.
    initial begin
        t_fb_req     r;
        t_reply      want;
        logic [31:0] id;
        int unsigned n_dir;
        int unsigned next_switch;
        int unsigned pick;
        bit          drained_once;

        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = $urandom;
        drained_once = 1'b0;
        next_switch  = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].rep; k++) begin
                r.cmd        = dir_rows[i].cmd;
                r.fb_id      = dir_rows[i].fb_id + k;
                r.bits       = dir_rows[i].bits;
                r.force_clr  = dir_rows[i].force_clr;
                r.scissor    = dir_rows[i].scissor;
                r.last       = dir_rows[i].last && (k == dir_rows[i].rep - 1);
                want.clear_bits = dir_rows[i].exp_bits;
                want.status     = dir_rows[i].exp_stat;
                send_req(r, dir_rows[i].typed, want);
            end
        end
        n_dir = n_sent;
        drain_results();

        while (n_sent < n_dir + RANDOM_ITEMS) begin
            // Alternate stretches of random stalls with stretches of none.
            if (n_sent >= next_switch) begin
                steady_run  = ($urandom_range(0, 3) == 0);
                next_switch = n_sent + 40;
            end
            if (!drained_once && n_sent >= n_dir + 400) begin
                drain_results();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                // A frame: bind an id, maybe create it, then draws and clears.
                id = pick_id();
                send_req(make_req(CMD_BIND, id), 1'b0, '0);
                if ($urandom_range(0, 3) == 0) send_req(make_req(CMD_CREATE, id), 1'b0, '0);
                repeat ($urandom_range(2, 6)) begin
                    send_req(make_req($urandom_range(0, 1) ? CMD_DRAW : CMD_CLEAR, id),
                             1'b0, '0);
                end
            end else begin
                // Table maintenance and noise.
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    send_req(make_req(CMD_CREATE, pick_id()), 1'b0, '0);
                else if (pick < 15)
                    send_req(make_req(CMD_DELETE, pick_id()), 1'b0, '0);
                else if (pick == 15)
                    send_req(make_req(CMD_RESET, $urandom), 1'b0, '0);
                else if (pick == 16)
                    send_req(make_req($urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7,
                                      $urandom), 1'b0, '0);
                else
                    send_req(make_req(CMD_BIND, $urandom), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2 * (TABLE_ENTRIES + 3)) @(posedge i_clk);

        $display("Run covered %0d requests (%0d directed), %0d clears with buffers elided,",
                 n_sent, n_dir, n_elided);
        $display("%0d lookups that missed and %0d creates into a full table.",
                 n_missing, n_full);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls, then each accepted result is checked in order.
    initial begin
        int unsigned gap;
        t_reply      want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with none expected", m_axis_tdata));
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tdata[2:0] !== want.clear_bits)
                    report_mismatch($sformatf("clear_bits %0d, expected %0d",
                                              m_axis_tdata[2:0], want.clear_bits));
                if (m_axis_tdata[4:3] !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[4:3], want.status));
                if (m_axis_tdata[7:5] !== 3'b000)
                    report_mismatch($sformatf("pad bits %b not zero", m_axis_tdata[7:5]));
            end
        end
    end

    // Watchdog: ends the run when no request or result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                         idle_cycles, replies_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
